// ----- sv/ihex_pkg.sv -----
// Shared types, codes and helpers for the Intel HEX record parser.
// No dependencies; imported by intel_hex_record_parser.
`default_nettype none

package ihex_pkg;

  // Parser phase within one record.
  typedef enum logic [2:0] {
    PH_WAIT = 3'd0,
    PH_LEN  = 3'd1,
    PH_AHI  = 3'd2,
    PH_ALO  = 3'd3,
    PH_TYPE = 3'd4,
    PH_DATA = 3'd5,
    PH_SUM  = 3'd6,
    PH_DONE = 3'd7
  } phase_t;

  localparam logic [1:0] CMD_BYTE    = 2'd0;
  localparam logic [1:0] CMD_END     = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_RECORD = 2'd1;
  localparam logic [1:0] KIND_EOF    = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_DIGIT    = 3'd1;
  localparam logic [2:0] ERR_TYPE     = 3'd2;
  localparam logic [2:0] ERR_CHECKSUM = 3'd3;
  localparam logic [2:0] ERR_EARLY    = 3'd4;

  localparam logic [7:0] CHAR_COLON = 8'h3A;

  // One result item as it travels through the output register and skid stage.
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] byte_address;
    logic [7:0]  data_byte;
    logic        record_type;
    logic [7:0]  record_length;
    logic [2:0]  error_code;
  } result_t;

  // Bit 4 flags a valid hex digit; bits 3:0 hold its value.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/intel_hex_record_parser.sv -----
// Intel HEX record parser top level: byte-wide decoder with an output skid stage.
// Depends on ihex_pkg for phase, command, kind and error codes.
`default_nettype none

// Takes one ASCII character (or an end-of-input or restart command) per transfer
// and returns at most one result per item: a data byte with its address, a record
// accept, an end-of-file accept or an error. The only loop is the parser state
// update, an 8-bit add and a digit decode, so a new item can be accepted every
// cycle while in_ready is high. Results leave through an output register backed by
// one skid entry: in_ready drops only while that skid entry is occupied. After an
// error or an accepted end-of-file record the parser ignores input until restart.
module intel_hex_record_parser
  import ihex_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  command,
  input  wire logic [7:0]  stream_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       kind,
  output logic [15:0]      byte_address,
  output logic [7:0]       data_byte,
  output logic             record_type,
  output logic [7:0]       record_length,
  output logic [2:0]       error_code
);

  phase_t      phase, phase_next;
  logic        nibble_pending, nibble_pending_next;
  logic [3:0]  high_nibble, high_nibble_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  length_held, length_held_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [15:0] record_address, record_address_next;
  logic        type_held, type_held_next;
  logic [15:0] next_address, next_address_next;
  logic        stopped, stopped_next;

  result_t     res;
  logic        has_result;
  logic        accept;
  logic        push;
  logic [4:0]  digit;
  logic [7:0]  dbyte;
  logic [7:0]  sum_new;

  result_t     out_q;
  result_t     skid_q;
  logic        skid_valid;

  assign in_ready = !skid_valid;
  assign accept   = in_valid && in_ready;
  assign push     = accept && has_result;

  assign digit   = hex_digit(stream_byte);
  assign dbyte   = {high_nibble, digit[3:0]};
  assign sum_new = running_sum + dbyte;

  always_comb begin
    phase_next          = phase;
    nibble_pending_next = nibble_pending;
    high_nibble_next    = high_nibble;
    running_sum_next    = running_sum;
    length_held_next    = length_held;
    bytes_left_next     = bytes_left;
    record_address_next = record_address;
    type_held_next      = type_held;
    next_address_next   = next_address;
    stopped_next        = stopped;
    has_result          = 1'b0;
    res.kind            = KIND_ERROR;
    res.byte_address    = record_address;
    res.data_byte       = 8'd0;
    res.record_type     = type_held;
    res.record_length   = length_held;
    res.error_code      = ERR_NONE;

    if (command == CMD_RESTART) begin
      phase_next          = PH_WAIT;
      nibble_pending_next = 1'b0;
      high_nibble_next    = 4'd0;
      running_sum_next    = 8'd0;
      length_held_next    = 8'd0;
      bytes_left_next     = 8'd0;
      record_address_next = 16'd0;
      type_held_next      = 1'b0;
      next_address_next   = 16'd0;
      stopped_next        = 1'b0;
    end else if (command == CMD_BYTE || command == CMD_END) begin
      if (!stopped && phase != PH_DONE) begin
        if (command == CMD_END) begin
          has_result     = 1'b1;
          res.error_code = ERR_EARLY;
          stopped_next   = 1'b1;
        end else if (phase == PH_WAIT) begin
          if (stream_byte == CHAR_COLON) begin
            running_sum_next    = 8'd0;
            length_held_next    = 8'd0;
            record_address_next = 16'd0;
            type_held_next      = 1'b0;
            nibble_pending_next = 1'b0;
            phase_next          = PH_LEN;
          end
        end else if (!digit[4]) begin
          has_result     = 1'b1;
          res.error_code = ERR_DIGIT;
          stopped_next   = 1'b1;
        end else if (!nibble_pending) begin
          high_nibble_next    = digit[3:0];
          nibble_pending_next = 1'b1;
        end else begin
          nibble_pending_next = 1'b0;
          running_sum_next    = sum_new;
          unique case (phase)
            PH_LEN: begin
              length_held_next = dbyte;
              bytes_left_next  = dbyte;
              phase_next       = PH_AHI;
            end
            PH_AHI: begin
              record_address_next = {dbyte, 8'd0};
              phase_next          = PH_ALO;
            end
            PH_ALO: begin
              record_address_next = {record_address[15:8], dbyte};
              next_address_next   = {record_address[15:8], dbyte};
              phase_next          = PH_TYPE;
            end
            PH_TYPE: begin
              if (dbyte[7:1] != 7'd0) begin
                has_result     = 1'b1;
                res.error_code = ERR_TYPE;
                stopped_next   = 1'b1;
              end else begin
                type_held_next = dbyte[0];
                phase_next     = (bytes_left != 8'd0) ? PH_DATA : PH_SUM;
              end
            end
            PH_DATA: begin
              has_result        = 1'b1;
              res.kind          = KIND_DATA;
              res.byte_address  = next_address;
              res.data_byte     = dbyte;
              next_address_next = next_address + 16'd1;
              bytes_left_next   = bytes_left - 8'd1;
              if (bytes_left == 8'd1) begin
                phase_next = PH_SUM;
              end
            end
            default: begin
              // Checksum byte: the full record must sum to zero.
              has_result = 1'b1;
              if (sum_new != 8'd0) begin
                res.error_code = ERR_CHECKSUM;
                stopped_next   = 1'b1;
              end else if (type_held) begin
                res.kind   = KIND_EOF;
                phase_next = PH_DONE;
              end else begin
                res.kind   = KIND_RECORD;
                phase_next = PH_WAIT;
              end
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_WAIT;
      nibble_pending <= 1'b0;
      high_nibble    <= 4'd0;
      running_sum    <= 8'd0;
      length_held    <= 8'd0;
      bytes_left     <= 8'd0;
      record_address <= 16'd0;
      type_held      <= 1'b0;
      next_address   <= 16'd0;
      stopped        <= 1'b0;
    end else if (accept) begin
      phase          <= phase_next;
      nibble_pending <= nibble_pending_next;
      high_nibble    <= high_nibble_next;
      running_sum    <= running_sum_next;
      length_held    <= length_held_next;
      bytes_left     <= bytes_left_next;
      record_address <= record_address_next;
      type_held      <= type_held_next;
      next_address   <= next_address_next;
      stopped        <= stopped_next;
    end
  end

  // A result that arrives while the output register is stalled waits in the skid
  // entry; in_ready is low while it is full, so it is never overwritten.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_q      <= skid_q;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
        if (push) begin
          out_q <= res;
        end
      end
    end else if (push) begin
      skid_q     <= res;
      skid_valid <= 1'b1;
    end
  end

  assign kind          = out_q.kind;
  assign byte_address  = out_q.byte_address;
  assign data_byte     = out_q.data_byte;
  assign record_type   = out_q.record_type;
  assign record_length = out_q.record_length;
  assign error_code    = out_q.error_code;

endmodule

`default_nettype wire
